FILE: src/arp_resolution_engine_macros.svh
// ----------------------------------------------------------------------------
// arp resolution engine assertion macros
// shared property shapes for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef ARP_RESOLUTION_ENGINE_MACROS_SVH
`define ARP_RESOLUTION_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ARE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("arp resolution engine check failed");

// next-cycle implication, disabled while reset is low
`define ARE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("arp resolution engine check failed");

`endif

FILE: src/are_pkg.sv
// ----------------------------------------------------------------------------
// are_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package are_pkg;

    // table sizes
    localparam int CACHE_ENTRIES   = 16;
    localparam int REQUEST_ENTRIES = 8;
    localparam int PENDING_SLOTS   = 16;

    localparam int CACHE_IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int REQ_IW   = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
    localparam int PEND_IW  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    localparam int SCAN_N0 = (CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES
                                                               : REQUEST_ENTRIES;
    localparam int SCAN_N  = (SCAN_N0 > PENDING_SLOTS) ? SCAN_N0 : PENDING_SLOTS;
    localparam int SCAN_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int PEND_CW = $clog2(PENDING_SLOTS + 1);

    // register reset values and broadcast address
    localparam logic [15:0] REQ_TIMEOUT_RESET   = 16'd5000;
    localparam logic [19:0] CACHE_TIMEOUT_RESET = 20'd30000;
    localparam logic [47:0] MAC_BCAST           = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_SEND = 2'd0,
        FUNC_RECV = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        FT_IPV4  = 2'd0,
        FT_ARP   = 2'd1,
        FT_OTHER = 2'd2,
        FT_RSVD  = 2'd3
    } ftype_t;

    typedef enum logic [2:0] {
        KIND_IPV4      = 3'd0,
        KIND_ARP_REQ   = 3'd1,
        KIND_ARP_REPLY = 3'd2,
        KIND_DELIVER   = 3'd3,
        KIND_DROP      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CFG_OWN_MAC    = 2'd0,
        CFG_OWN_IP     = 2'd1,
        CFG_REQ_TMO    = 2'd2,
        CFG_CACHE_TMO  = 2'd3
    } cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic  capture;
        logic  now_add;
        logic  idx_clr;
        logic  idx_ld_cmatch;
        logic  idx_ld_rmatch;
        logic  sel_ld_idx;
        logic  sel_ld_cmatch;
        logic  sel_ld_cfree;
        logic  sel_ld_rfree;
        logic  best_clr;
        logic  cache_old_step;
        logic  req_old_step;
        logic  cache_inval_idx;
        logic  cache_write;
        logic  pend_alloc;
        logic  pend_inval_sel;
        logic  req_write;
        logic  req_inval_match;
        logic  flush_step;
        logic  tick_step;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  emit_flush;
    } are_cmd_t;

    // datapath to controller
    typedef struct packed {
        func_t  func;
        ftype_t ftype;
        logic   frame_ok;
        logic   reply_need;
        logic   cache_match;
        logic   cache_free;
        logic   cache_live;
        logic   req_match;
        logic   req_free;
        logic   req_live;
        logic   pend_free;
        logic   cache_end;
        logic   req_end;
        logic   pend_end;
        logic   tick_end;
        logic   found;
        logic   cnt_one;
        logic   out_free;
    } are_sts_t;

endpackage

FILE: src/are_ctrl.sv
// ----------------------------------------------------------------------------
// are_ctrl
// sequencer that walks one item through lookups, table scans and result transfers
// ----------------------------------------------------------------------------
module are_ctrl
    import are_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  are_sts_t sts,
    output are_cmd_t cmd
);

    typedef enum logic [15:0] {
        ST_IDLE      = 16'h0001,
        ST_DECODE    = 16'h0002,
        ST_SND_CHK   = 16'h0004,
        ST_SND_PEND  = 16'h0008,
        ST_SND_RCHK  = 16'h0010,
        ST_SND_DROP  = 16'h0020,
        ST_SND_ROLD  = 16'h0040,
        ST_SND_RWR   = 16'h0080,
        ST_ARP_CST   = 16'h0100,
        ST_ARP_COLD  = 16'h0200,
        ST_ARP_CWR   = 16'h0400,
        ST_ARP_FSCAN = 16'h0800,
        ST_ARP_FEMIT = 16'h1000,
        ST_ARP_REPLY = 16'h2000,
        ST_EMIT_UP   = 16'h4000,
        ST_TICK      = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   drop_reg, drop_next;
    logic   issue_reg, issue_next;
    logic   scan_reg, scan_next;
    logic   rmatch_reg, rmatch_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        drop_next   = drop_reg;
        issue_next  = issue_reg;
        scan_next   = scan_reg;
        rmatch_next = rmatch_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.func)
                    FUNC_SEND: begin
                        if (sts.cache_match) begin
                            cmd.idx_ld_cmatch = 1'b1;
                            state_next        = ST_SND_CHK;
                        end else begin
                            state_next = ST_SND_PEND;
                        end
                    end
                    FUNC_RECV: begin
                        if (!sts.frame_ok) begin
                            state_next = ST_IDLE;
                        end else if (sts.ftype == FT_IPV4) begin
                            state_next = ST_EMIT_UP;
                        end else if (sts.ftype == FT_ARP) begin
                            state_next = ST_ARP_CST;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_TICK: begin
                        cmd.now_add = 1'b1;
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_TICK;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SND_CHK: begin
                if (sts.cache_live) begin
                    if (sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_IPV4;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.cache_inval_idx = 1'b1;
                    state_next          = ST_SND_PEND;
                end
            end
            ST_SND_PEND: begin
                drop_next         = !sts.pend_free;
                cmd.pend_alloc    = sts.pend_free;
                cmd.idx_ld_rmatch = 1'b1;
                rmatch_next       = sts.req_match;
                state_next        = ST_SND_RCHK;
            end
            ST_SND_RCHK: begin
                issue_next = !(rmatch_reg && sts.req_live);
                scan_next  = 1'b0;
                if (rmatch_reg) begin
                    cmd.sel_ld_idx = 1'b1;
                end else if (sts.req_free) begin
                    cmd.sel_ld_rfree = 1'b1;
                end else begin
                    scan_next    = 1'b1;
                    cmd.best_clr = 1'b1;
                    cmd.idx_clr  = 1'b1;
                end
                if (drop_reg) begin
                    state_next = ST_SND_DROP;
                end else if (!issue_next) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = scan_next ? ST_SND_ROLD : ST_SND_RWR;
                end
            end
            ST_SND_DROP: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DROP;
                    cmd.emit_last = !issue_reg;
                    if (!issue_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = scan_reg ? ST_SND_ROLD : ST_SND_RWR;
                    end
                end
            end
            ST_SND_ROLD: begin
                cmd.req_old_step = 1'b1;
                if (sts.req_end) begin
                    state_next = ST_SND_RWR;
                end
            end
            ST_SND_RWR: begin
                if (sts.out_free) begin
                    cmd.req_write = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ARP_REQ;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ARP_CST: begin
                if (sts.cache_match) begin
                    cmd.sel_ld_cmatch = 1'b1;
                    state_next        = ST_ARP_CWR;
                end else if (sts.cache_free) begin
                    cmd.sel_ld_cfree = 1'b1;
                    state_next       = ST_ARP_CWR;
                end else begin
                    cmd.best_clr = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = ST_ARP_COLD;
                end
            end
            ST_ARP_COLD: begin
                cmd.cache_old_step = 1'b1;
                if (sts.cache_end) begin
                    state_next = ST_ARP_CWR;
                end
            end
            ST_ARP_CWR: begin
                cmd.cache_write     = 1'b1;
                cmd.req_inval_match = 1'b1;
                cmd.idx_clr         = 1'b1;
                cmd.best_clr        = 1'b1;
                state_next          = ST_ARP_FSCAN;
            end
            ST_ARP_FSCAN: begin
                cmd.flush_step = 1'b1;
                if (sts.pend_end) begin
                    state_next = ST_ARP_FEMIT;
                end
            end
            ST_ARP_FEMIT: begin
                if (!sts.found) begin
                    state_next = sts.reply_need ? ST_ARP_REPLY : ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit           = 1'b1;
                    cmd.emit_kind      = KIND_IPV4;
                    cmd.emit_flush     = 1'b1;
                    cmd.emit_last      = sts.cnt_one && !sts.reply_need;
                    cmd.pend_inval_sel = 1'b1;
                    cmd.idx_clr        = 1'b1;
                    cmd.best_clr       = 1'b1;
                    state_next         = ST_ARP_FSCAN;
                end
            end
            ST_ARP_REPLY: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ARP_REPLY;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_UP: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DELIVER;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK: begin
                cmd.tick_step = 1'b1;
                if (sts.tick_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and decision flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            drop_reg   <= 1'b0;
            issue_reg  <= 1'b0;
            scan_reg   <= 1'b0;
            rmatch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            drop_reg   <= drop_next;
            issue_reg  <= issue_next;
            scan_reg   <= scan_next;
            rmatch_reg <= rmatch_next;
        end
    end

endmodule

FILE: src/are_datapath.sv
// ----------------------------------------------------------------------------
// are_datapath
// address tables, item capture, scan index and result register
// ----------------------------------------------------------------------------
module are_datapath
    import are_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  are_cmd_t    cmd,
    output are_sts_t    sts,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    // input item
    input  logic [1:0]  s_func,
    input  logic [31:0] s_peer_ip,
    input  logic [15:0] s_packet_tag,
    input  logic [47:0] s_frame_dst_mac,
    input  logic [1:0]  s_frame_type,
    input  logic        s_payload_ok,
    input  logic        s_arp_is_request,
    input  logic [31:0] s_arp_sender_ip,
    input  logic [47:0] s_arp_sender_mac,
    input  logic [31:0] s_arp_target_ip,
    input  logic [15:0] s_elapsed_ms,
    // result item
    input  logic        m_ready,
    output logic        m_valid,
    output logic [2:0]  m_out_kind,
    output logic [47:0] m_dest_mac,
    output logic [31:0] m_target_ip,
    output logic [15:0] m_out_tag,
    output logic        m_last
);

    // configuration registers
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [15:0] req_tmo_reg;
    logic [19:0] cache_tmo_reg;

    // captured item
    logic [1:0]  in_func_reg;
    logic [31:0] in_peer_reg;
    logic [15:0] in_tag_reg;
    logic [47:0] in_dst_reg;
    logic [1:0]  in_ftype_reg;
    logic        in_ok_reg;
    logic        in_isreq_reg;
    logic [31:0] in_sip_reg;
    logic [47:0] in_smac_reg;
    logic [31:0] in_tip_reg;
    logic [15:0] in_elapsed_reg;

    // tables
    logic [31:0] now_reg;
    logic [15:0] arrival_reg;
    logic [CACHE_ENTRIES-1:0]   cache_valid_reg;
    logic [31:0]                cache_ip_reg   [CACHE_ENTRIES];
    logic [47:0]                cache_mac_reg  [CACHE_ENTRIES];
    logic [31:0]                cache_time_reg [CACHE_ENTRIES];
    logic [REQUEST_ENTRIES-1:0] req_valid_reg;
    logic [31:0]                req_ip_reg     [REQUEST_ENTRIES];
    logic [31:0]                req_time_reg   [REQUEST_ENTRIES];
    logic [PENDING_SLOTS-1:0]   pend_valid_reg;
    logic [31:0]                pend_ip_reg     [PENDING_SLOTS];
    logic [15:0]                pend_handle_reg [PENDING_SLOTS];
    logic [31:0]                pend_time_reg   [PENDING_SLOTS];
    logic [15:0]                pend_order_reg  [PENDING_SLOTS];

    // scan state
    logic [SCAN_W-1:0]  idx_reg;
    logic [SCAN_W-1:0]  sel_reg;
    logic [31:0]        best_reg;
    logic               found_reg;
    logic [PEND_CW-1:0] cnt_reg;
    logic [15:0]        ftag_reg;

    // result register
    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [47:0] m_mac_reg;
    logic [31:0] m_tip_reg;
    logic [15:0] m_tag_reg;
    logic        m_last_reg;

    logic [CACHE_IW-1:0] ci;
    logic [REQ_IW-1:0]   ri;
    logic [PEND_IW-1:0]  pi;
    logic [CACHE_IW-1:0] si_c;
    logic [REQ_IW-1:0]   si_r;
    logic [PEND_IW-1:0]  si_p;
    logic [31:0]         key_ip;
    logic                cmatch_any, cfree_any, rmatch_any, rfree_any, pfree_any;
    logic [CACHE_IW-1:0] cmatch_idx, cfree_idx;
    logic [REQ_IW-1:0]   rmatch_idx, rfree_idx;
    logic [PEND_IW-1:0]  pfree_idx;
    logic [31:0]         cache_age, req_age, pend_age;
    logic [15:0]         flush_age;
    logic                in_cache, in_req, in_pend;
    logic                out_free;

    assign ci   = idx_reg[CACHE_IW-1:0];
    assign ri   = idx_reg[REQ_IW-1:0];
    assign pi   = idx_reg[PEND_IW-1:0];
    assign si_c = sel_reg[CACHE_IW-1:0];
    assign si_r = sel_reg[REQ_IW-1:0];
    assign si_p = sel_reg[PEND_IW-1:0];

    assign key_ip = (func_t'(in_func_reg) == FUNC_SEND) ? in_peer_reg : in_sip_reg;

    // ages of the entry under the scan index
    assign cache_age = now_reg - cache_time_reg[ci];
    assign req_age   = now_reg - req_time_reg[ri];
    assign pend_age  = now_reg - pend_time_reg[pi];
    assign flush_age = arrival_reg - pend_order_reg[pi];

    assign in_cache = {1'b0, idx_reg} < (SCAN_W + 1)'(CACHE_ENTRIES);
    assign in_req   = {1'b0, idx_reg} < (SCAN_W + 1)'(REQUEST_ENTRIES);
    assign in_pend  = {1'b0, idx_reg} < (SCAN_W + 1)'(PENDING_SLOTS);

    assign out_free = !m_valid_reg || m_ready;

    // lowest-index match and free searches
    always_comb begin
        cmatch_any = 1'b0;
        cmatch_idx = '0;
        cfree_any  = 1'b0;
        cfree_idx  = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (cache_valid_reg[i] && cache_ip_reg[i] == key_ip) begin
                cmatch_any = 1'b1;
                cmatch_idx = CACHE_IW'(i);
            end
            if (!cache_valid_reg[i]) begin
                cfree_any = 1'b1;
                cfree_idx = CACHE_IW'(i);
            end
        end
        rmatch_any = 1'b0;
        rmatch_idx = '0;
        rfree_any  = 1'b0;
        rfree_idx  = '0;
        for (int i = REQUEST_ENTRIES - 1; i >= 0; i--) begin
            if (req_valid_reg[i] && req_ip_reg[i] == key_ip) begin
                rmatch_any = 1'b1;
                rmatch_idx = REQ_IW'(i);
            end
            if (!req_valid_reg[i]) begin
                rfree_any = 1'b1;
                rfree_idx = REQ_IW'(i);
            end
        end
        pfree_any = 1'b0;
        pfree_idx = '0;
        for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
            if (!pend_valid_reg[i]) begin
                pfree_any = 1'b1;
                pfree_idx = PEND_IW'(i);
            end
        end
    end

    // status to the controller
    always_comb begin
        sts.func        = func_t'(in_func_reg);
        sts.ftype       = ftype_t'(in_ftype_reg);
        sts.frame_ok    = (in_dst_reg == own_mac_reg || in_dst_reg == MAC_BCAST) && in_ok_reg;
        sts.reply_need  = in_isreq_reg && (in_tip_reg == own_ip_reg);
        sts.cache_match = cmatch_any;
        sts.cache_free  = cfree_any;
        sts.cache_live  = cache_age < {12'd0, cache_tmo_reg};
        sts.req_match   = rmatch_any;
        sts.req_free    = rfree_any;
        sts.req_live    = req_age < {16'd0, req_tmo_reg};
        sts.pend_free   = pfree_any;
        sts.cache_end   = idx_reg == SCAN_W'(CACHE_ENTRIES - 1);
        sts.req_end     = idx_reg == SCAN_W'(REQUEST_ENTRIES - 1);
        sts.pend_end    = idx_reg == SCAN_W'(PENDING_SLOTS - 1);
        sts.tick_end    = idx_reg == SCAN_W'(SCAN_N - 1);
        sts.found       = found_reg;
        sts.cnt_one     = cnt_reg == PEND_CW'(1);
        sts.out_free    = out_free;
    end

    // control state: config, clock, valid bits, counters, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg     <= '0;
            own_ip_reg      <= '0;
            req_tmo_reg     <= REQ_TIMEOUT_RESET;
            cache_tmo_reg   <= CACHE_TIMEOUT_RESET;
            now_reg         <= '0;
            arrival_reg     <= '0;
            cache_valid_reg <= '0;
            req_valid_reg   <= '0;
            pend_valid_reg  <= '0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_OWN_MAC:   own_mac_reg   <= cfg_wdata;
                    CFG_OWN_IP:    own_ip_reg    <= cfg_wdata[31:0];
                    CFG_REQ_TMO:   req_tmo_reg   <= cfg_wdata[15:0];
                    CFG_CACHE_TMO: cache_tmo_reg <= cfg_wdata[19:0];
                    default:       own_mac_reg   <= own_mac_reg;
                endcase
            end
            if (cmd.now_add) begin
                now_reg <= now_reg + {16'd0, in_elapsed_reg};
            end
            // scan index
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_ld_cmatch) begin
                idx_reg <= SCAN_W'(cmatch_idx);
            end else if (cmd.idx_ld_rmatch) begin
                idx_reg <= SCAN_W'(rmatch_idx);
            end else if (cmd.cache_old_step || cmd.req_old_step ||
                         cmd.flush_step || cmd.tick_step) begin
                idx_reg <= idx_reg + SCAN_W'(1);
            end
            // valid bits
            if (cmd.cache_inval_idx) begin
                cache_valid_reg[ci] <= 1'b0;
            end
            if (cmd.cache_write) begin
                cache_valid_reg[si_c] <= 1'b1;
            end
            if (cmd.req_write) begin
                req_valid_reg[si_r] <= 1'b1;
            end
            if (cmd.req_inval_match) begin
                for (int i = 0; i < REQUEST_ENTRIES; i++) begin
                    if (req_valid_reg[i] && req_ip_reg[i] == in_sip_reg) begin
                        req_valid_reg[i] <= 1'b0;
                    end
                end
            end
            if (cmd.pend_alloc) begin
                pend_valid_reg[pfree_idx] <= 1'b1;
                arrival_reg               <= arrival_reg + 16'd1;
            end
            if (cmd.pend_inval_sel) begin
                pend_valid_reg[si_p] <= 1'b0;
            end
            // expiry sweep
            if (cmd.tick_step) begin
                if (in_pend && pend_valid_reg[pi] && pend_age >= {16'd0, req_tmo_reg}) begin
                    pend_valid_reg[pi] <= 1'b0;
                end
                if (in_cache && cache_valid_reg[ci] &&
                    cache_age >= {12'd0, cache_tmo_reg}) begin
                    cache_valid_reg[ci] <= 1'b0;
                end
                if (in_req && req_valid_reg[ri] && req_age >= {16'd0, req_tmo_reg}) begin
                    req_valid_reg[ri] <= 1'b0;
                end
            end
            // flush pass bookkeeping
            if (cmd.best_clr) begin
                found_reg <= 1'b0;
                cnt_reg   <= '0;
            end else if (cmd.flush_step && pend_valid_reg[pi] &&
                         pend_ip_reg[pi] == in_sip_reg) begin
                cnt_reg <= cnt_reg + PEND_CW'(1);
                if (!found_reg || {16'd0, flush_age} > best_reg) begin
                    found_reg <= 1'b1;
                end
            end
            // result valid
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload: captured item, table entries, scan picks, result fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_func_reg    <= s_func;
            in_peer_reg    <= s_peer_ip;
            in_tag_reg     <= s_packet_tag;
            in_dst_reg     <= s_frame_dst_mac;
            in_ftype_reg   <= s_frame_type;
            in_ok_reg      <= s_payload_ok;
            in_isreq_reg   <= s_arp_is_request;
            in_sip_reg     <= s_arp_sender_ip;
            in_smac_reg    <= s_arp_sender_mac;
            in_tip_reg     <= s_arp_target_ip;
            in_elapsed_reg <= s_elapsed_ms;
        end
        if (cmd.cache_write) begin
            cache_ip_reg[si_c]   <= in_sip_reg;
            cache_mac_reg[si_c]  <= in_smac_reg;
            cache_time_reg[si_c] <= now_reg;
        end
        if (cmd.req_write) begin
            req_ip_reg[si_r]   <= in_peer_reg;
            req_time_reg[si_r] <= now_reg;
        end
        if (cmd.pend_alloc) begin
            pend_ip_reg[pfree_idx]     <= in_peer_reg;
            pend_handle_reg[pfree_idx] <= in_tag_reg;
            pend_time_reg[pfree_idx]   <= now_reg;
            pend_order_reg[pfree_idx]  <= arrival_reg;
        end
        // slot selection and oldest-entry scans
        if (cmd.best_clr) begin
            best_reg <= '0;
            sel_reg  <= '0;
        end else if (cmd.sel_ld_idx) begin
            sel_reg <= idx_reg;
        end else if (cmd.sel_ld_cmatch) begin
            sel_reg <= SCAN_W'(cmatch_idx);
        end else if (cmd.sel_ld_cfree) begin
            sel_reg <= SCAN_W'(cfree_idx);
        end else if (cmd.sel_ld_rfree) begin
            sel_reg <= SCAN_W'(rfree_idx);
        end else if (cmd.cache_old_step) begin
            if (cache_age > best_reg) begin
                best_reg <= cache_age;
                sel_reg  <= idx_reg;
            end
        end else if (cmd.req_old_step) begin
            if (req_age > best_reg) begin
                best_reg <= req_age;
                sel_reg  <= idx_reg;
            end
        end else if (cmd.flush_step && pend_valid_reg[pi] &&
                     pend_ip_reg[pi] == in_sip_reg) begin
            if (!found_reg || {16'd0, flush_age} > best_reg) begin
                best_reg <= {16'd0, flush_age};
                sel_reg  <= idx_reg;
                ftag_reg <= pend_handle_reg[pi];
            end
        end
        // result fields
        if (cmd.emit) begin
            m_kind_reg <= cmd.emit_kind;
            m_last_reg <= cmd.emit_last;
            case (cmd.emit_kind)
                KIND_IPV4: begin
                    m_mac_reg <= cmd.emit_flush ? in_smac_reg : cache_mac_reg[ci];
                    m_tip_reg <= '0;
                    m_tag_reg <= cmd.emit_flush ? ftag_reg : in_tag_reg;
                end
                KIND_ARP_REQ: begin
                    m_mac_reg <= MAC_BCAST;
                    m_tip_reg <= in_peer_reg;
                    m_tag_reg <= '0;
                end
                KIND_ARP_REPLY: begin
                    m_mac_reg <= in_smac_reg;
                    m_tip_reg <= in_sip_reg;
                    m_tag_reg <= '0;
                end
                default: begin
                    m_mac_reg <= '0;
                    m_tip_reg <= '0;
                    m_tag_reg <= in_tag_reg;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_kind  = m_kind_reg;
    assign m_dest_mac  = m_mac_reg;
    assign m_target_ip = m_tip_reg;
    assign m_out_tag   = m_tag_reg;
    assign m_last      = m_last_reg;

endmodule

FILE: src/arp_resolution_engine.sv
// ----------------------------------------------------------------------------
// arp_resolution_engine
// next-hop resolution with address cache, request table and pending datagrams
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    send, received frame or tick item
//  m_*       out        m_valid / m_ready    frame, request, reply, deliver, drop
//  cfg_*     in         cfg_wr_en            own_mac, own_ip, timeouts
//
//  one item at a time; s_ready is high only while the sequencer is idle.
//  send: the request table's oldest entry is searched when the table is full;
//  arp frame: one flush pass over the pending store per flushed datagram plus
//  one, and the cache's oldest entry is searched when the cache is full;
//  tick: one expiry sweep over the tables.
//  reset is synchronous; valid bits clear at once, no clearing pass.
//  a stalled result holds the sequencer in its emit state; one result register.
// ----------------------------------------------------------------------------
`include "arp_resolution_engine_macros.svh"

module arp_resolution_engine
    import are_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_peer_ip,
    input  logic [15:0] s_packet_tag,
    input  logic [47:0] s_frame_dst_mac,
    input  logic [1:0]  s_frame_type,
    input  logic        s_payload_ok,
    input  logic        s_arp_is_request,
    input  logic [31:0] s_arp_sender_ip,
    input  logic [47:0] s_arp_sender_mac,
    input  logic [31:0] s_arp_target_ip,
    input  logic [15:0] s_elapsed_ms,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [47:0] m_dest_mac,
    output logic [31:0] m_target_ip,
    output logic [15:0] m_out_tag,
    output logic        m_last
);

    are_cmd_t cmd;
    are_sts_t sts;

    // sequencer
    are_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // tables and result register
    are_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_func           (s_func),
        .s_peer_ip        (s_peer_ip),
        .s_packet_tag     (s_packet_tag),
        .s_frame_dst_mac  (s_frame_dst_mac),
        .s_frame_type     (s_frame_type),
        .s_payload_ok     (s_payload_ok),
        .s_arp_is_request (s_arp_is_request),
        .s_arp_sender_ip  (s_arp_sender_ip),
        .s_arp_sender_mac (s_arp_sender_mac),
        .s_arp_target_ip  (s_arp_target_ip),
        .s_elapsed_ms     (s_elapsed_ms),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_out_kind       (m_out_kind),
        .m_dest_mac       (m_dest_mac),
        .m_target_ip      (m_target_ip),
        .m_out_tag        (m_out_tag),
        .m_last           (m_last)
    );

    // checks
    `ARE_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ARE_ASSERT_SAME(a_request_is_bcast, aclk, aresetn, m_valid && m_out_kind == KIND_ARP_REQ, m_dest_mac == MAC_BCAST && m_last)
    `ARE_ASSERT_SAME(a_single_results_last, aclk, aresetn, m_valid && (m_out_kind == KIND_DELIVER || m_out_kind == KIND_ARP_REPLY), m_last)

endmodule
